### rtl/core/usx_pkg.sv
// Shared types, constants and text tables of the UTF-8 / XML stream sanitizer.
package usx_pkg;

	localparam int SEG_MAX        = 6;
	localparam int SEG_IDX_W      = $clog2(SEG_MAX);
	localparam int SEG_CNT_W      = $clog2(SEG_MAX + 1);
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int PADDR_W        = 4;

	localparam logic        ESCAPE_RST     = 1'b1;
	localparam logic [31:0] BAD_LIMIT_RST  = 32'd100;
	localparam logic [31:0] GOOD_LIMIT_RST = 32'd100000;
	localparam logic [15:0] LINE_LIMIT_RST = 16'd80;

	typedef enum logic [1:0] {
		REG_ESCAPE     = 2'd0,
		REG_BAD_LIMIT  = 2'd1,
		REG_GOOD_LIMIT = 2'd2,
		REG_LINE_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_RUN   = 2'd0,
		ST_OVER  = 2'd1,
		ST_ABORT = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SEG_STR = 2'd0,
		SEG_HEX = 2'd1,
		SEG_RAW = 2'd2
	} seg_kind_t;

	typedef enum logic [3:0] {
		STR_BAD   = 4'd0,
		STR_LONE  = 4'd1,
		STR_UNFIN = 4'd2,
		STR_ABORT = 4'd3,
		STR_OVER  = 4'd4,
		STR_SPLIT = 4'd5,
		STR_AMP   = 4'd6,
		STR_LT    = 4'd7,
		STR_GT    = 4'd8,
		STR_APOS  = 4'd9,
		STR_QUOT  = 4'd10
	} str_id_t;

	typedef struct packed {
		seg_kind_t   kind;
		str_id_t     id;
		logic [7:0]  data;
	} seg_t;

	// One queued output run: up to SEG_MAX segments, emitted in index order.
	typedef struct packed {
		seg_t [SEG_MAX-1:0]   segs;
		logic [SEG_CNT_W-1:0] count;
		status_t              status;
	} run_t;

	typedef struct packed {
		logic        escape_enable;
		logic [31:0] bad_limit;
		logic [31:0] good_limit;
		logic [15:0] line_limit;
	} cfg_t;

	localparam logic [255:0] TXT_BAD   = "&#x275a;";
	localparam logic [255:0] TXT_LONE  = "&#x2762;";
	localparam logic [255:0] TXT_UNFIN = "&#x271c;";
	localparam logic [255:0] TXT_ABORT = "&#x2639;&#x2639;&#x2639;\n";
	localparam logic [255:0] TXT_OVER  = "&#x2340;&#x2340;&#x2340;";
	localparam logic [255:0] TXT_SPLIT = "&#x21a9;\n&#x21aa;";
	localparam logic [255:0] TXT_AMP   = "&amp;";
	localparam logic [255:0] TXT_LT    = "&lt;";
	localparam logic [255:0] TXT_GT    = "&gt;";
	localparam logic [255:0] TXT_APOS  = "&apos;";
	localparam logic [255:0] TXT_QUOT  = "&quot;";

	function automatic logic [4:0] str_len(input str_id_t id);
		logic [4:0] len;
		unique case (id)
			STR_BAD, STR_LONE, STR_UNFIN: len = 5'd8;
			STR_ABORT: len = 5'd25;
			STR_OVER:  len = 5'd24;
			STR_SPLIT: len = 5'd17;
			STR_AMP:   len = 5'd5;
			STR_LT, STR_GT: len = 5'd4;
			STR_APOS, STR_QUOT: len = 5'd6;
			default:   len = 5'd1;
		endcase
		return len;
	endfunction

	// Character at offset off (from the left) of a marker string.
	function automatic logic [7:0] str_char(input str_id_t id, input logic [4:0] off);
		logic [255:0] s;
		logic [4:0]   idx;
		unique case (id)
			STR_BAD:   s = TXT_BAD;
			STR_LONE:  s = TXT_LONE;
			STR_UNFIN: s = TXT_UNFIN;
			STR_ABORT: s = TXT_ABORT;
			STR_OVER:  s = TXT_OVER;
			STR_SPLIT: s = TXT_SPLIT;
			STR_AMP:   s = TXT_AMP;
			STR_LT:    s = TXT_LT;
			STR_GT:    s = TXT_GT;
			STR_APOS:  s = TXT_APOS;
			STR_QUOT:  s = TXT_QUOT;
			default:   s = '0;
		endcase
		idx = str_len(id) - 5'd1 - off;
		return s[{idx, 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h37 + {4'h0, nib});
	endfunction

	function automatic seg_t mk_str(input str_id_t id);
		return '{kind: SEG_STR, id: id, data: 8'h00};
	endfunction

	function automatic seg_t mk_hex(input logic [7:0] b);
		return '{kind: SEG_HEX, id: STR_BAD, data: b};
	endfunction

	function automatic seg_t mk_raw(input logic [7:0] b);
		return '{kind: SEG_RAW, id: STR_BAD, data: b};
	endfunction

endpackage

### rtl/core/utf8_xml_stream_sanitizer_top.sv
// Top level of the UTF-8 / XML stream sanitizer: register port and unit wiring.
// Path: the first byte of a run goes through the run queue and then the output
// register; it waits behind queued runs and behind an output register that is not free.
// Throughput: one input transaction per cycle while runs are one byte long; a run
// holds the output stage until its last byte is taken, and input stalls when the run
// queue (QUEUE_DEPTH entries) is full. Reset is asynchronous and active low: it
// clears decoder, counters, stop status and queue, and loads register defaults.
module utf8_xml_stream_sanitizer_top #(
	parameter int QUEUE_DEPTH = usx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [usx_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	// input transactions
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        end_of_stream,
	// output transactions
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_byte,
	output logic                        last,
	output logic [1:0]                  status
);
	import usx_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	run_t push_data, head;
	logic push, pop, full, empty;

	// Registers sit at byte address 4*index; the low two address bits are ignored.
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.escape_enable <= ESCAPE_RST;
			cfg_q.bad_limit     <= BAD_LIMIT_RST;
			cfg_q.good_limit    <= GOOD_LIMIT_RST;
			cfg_q.line_limit    <= LINE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ESCAPE:     cfg_q.escape_enable <= pwdata[0];
				REG_BAD_LIMIT:  cfg_q.bad_limit     <= pwdata;
				REG_GOOD_LIMIT: cfg_q.good_limit    <= pwdata;
				REG_LINE_LIMIT: cfg_q.line_limit    <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero extended.
	always_comb begin
		unique case (reg_sel)
			REG_ESCAPE:     prdata = {31'b0, cfg_q.escape_enable};
			REG_BAD_LIMIT:  prdata = cfg_q.bad_limit;
			REG_GOOD_LIMIT: prdata = cfg_q.good_limit;
			REG_LINE_LIMIT: prdata = {16'b0, cfg_q.line_limit};
			default:        prdata = '0;
		endcase
	end

	// Front end: decode each input byte and queue a compact description of its run.
	usx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.end_of_stream (end_of_stream),
		.full          (full),
		.push          (push),
		.push_data     (push_data)
	);

	// Run queue: lets the front keep accepting while a long run drains.
	usx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.full   (full),
		.pop    (pop),
		.rdata  (head),
		.empty  (empty)
	);

	// Back end: walk the head run segment by segment into the output register.
	usx_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last),
		.status    (status)
	);

endmodule

### rtl/core/usx_front.sv
// Front end: UTF-8 decode, counters, limits and run classification.
module usx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  usx_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_stream,
	input  logic                 full,
	output logic                 push,
	output usx_pkg::run_t        push_data
);
	import usx_pkg::*;

	typedef enum logic [6:0] {
		MODE_SINGLE = 7'b0000001,
		MODE_2_1    = 7'b0000010,
		MODE_3_1    = 7'b0000100,
		MODE_3_2    = 7'b0001000,
		MODE_4_1    = 7'b0010000,
		MODE_4_2    = 7'b0100000,
		MODE_4_3    = 7'b1000000
	} mode_t;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_NL   = 8'h0A;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_DEL  = 8'h7F;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;

	mode_t       mode_q, mode_n;
	logic [7:0]  held_q [3];
	logic [7:0]  held_n [3];
	logic [31:0] bad_q, bad_n, good_q, good_n;
	logic [15:0] line_q, line_n;
	status_t     stop_q, stop_n;

	run_t                 run;
	logic [SEG_CNT_W-1:0] n;
	logic [1:0]           held_cnt;
	logic                 asc, bad_inc, good_ch, accept;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;
	assign good_ch  = (in_byte == CH_TAB) || (in_byte == CH_NL) ||
	                  ((in_byte >= CH_SP) && (in_byte < CH_DEL));

	always_comb begin
		unique case (mode_q)
			MODE_2_1, MODE_3_1, MODE_4_1: held_cnt = 2'd1;
			MODE_3_2, MODE_4_2: held_cnt = 2'd2;
			MODE_4_3: held_cnt = 2'd3;
			default: held_cnt = 2'd0;
		endcase
	end

	always_comb begin
		run     = '0;
		n       = '0;
		mode_n  = mode_q;
		held_n  = held_q;
		bad_n   = bad_q;
		good_n  = good_q;
		line_n  = line_q;
		stop_n  = stop_q;
		asc     = 1'b0;
		bad_inc = 1'b0;

		if (stop_q == ST_RUN) begin
			if (end_of_stream) begin
				if (held_cnt != 2'd0) begin
					run.segs[n] = mk_str(STR_UNFIN);
					n = n + 1'b1;
					for (int i = 0; i < 3; i++) begin
						if (2'(i) < held_cnt) begin
							run.segs[n] = mk_hex(held_q[i]);
							n = n + 1'b1;
						end
					end
				end
				mode_n = MODE_SINGLE;
			end else if ((cfg.bad_limit != 32'd0) && (bad_q > cfg.bad_limit)) begin
				run.segs[n] = mk_str(STR_ABORT);
				n = n + 1'b1;
				stop_n = ST_ABORT;
			end else if (held_cnt == 2'd0) begin
				if (!in_byte[7]) begin
					asc = 1'b1;
				end else if (!in_byte[6]) begin
					bad_inc = 1'b1;
					run.segs[n] = mk_str(STR_LONE);
					n = n + 1'b1;
					run.segs[n] = mk_hex(in_byte);
					n = n + 1'b1;
					mode_n = MODE_SINGLE;
				end else begin
					held_n[0] = in_byte;
					mode_n = (in_byte < 8'd224) ? MODE_2_1 :
					         (in_byte < 8'd240) ? MODE_3_1 : MODE_4_1;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				// Broken sequence: report held bytes, then the new byte.
				run.segs[n] = mk_str(STR_UNFIN);
				n = n + 1'b1;
				for (int i = 0; i < 3; i++) begin
					if (2'(i) < held_cnt) begin
						run.segs[n] = mk_hex(held_q[i]);
						n = n + 1'b1;
					end
				end
				bad_inc = 1'b1;
				if (good_ch) begin
					asc = 1'b1;
				end else begin
					run.segs[n] = mk_hex(in_byte);
					n = n + 1'b1;
					mode_n = MODE_SINGLE;
				end
			end else begin
				unique case (mode_q)
					MODE_2_1: begin
						run.segs[0] = mk_raw(held_q[0]);
						run.segs[1] = mk_raw(in_byte);
						n = SEG_CNT_W'(2);
						mode_n = MODE_SINGLE;
					end
					MODE_3_1: begin
						held_n[1] = in_byte;
						mode_n = MODE_3_2;
					end
					MODE_3_2: begin
						run.segs[0] = mk_raw(held_q[0]);
						run.segs[1] = mk_raw(held_q[1]);
						run.segs[2] = mk_raw(in_byte);
						n = SEG_CNT_W'(3);
						mode_n = MODE_SINGLE;
					end
					MODE_4_1: begin
						held_n[1] = in_byte;
						mode_n = MODE_4_2;
					end
					MODE_4_2: begin
						held_n[2] = in_byte;
						mode_n = MODE_4_3;
					end
					MODE_4_3: begin
						run.segs[0] = mk_raw(held_q[0]);
						run.segs[1] = mk_raw(held_q[1]);
						run.segs[2] = mk_raw(held_q[2]);
						run.segs[3] = mk_raw(in_byte);
						n = SEG_CNT_W'(4);
						mode_n = MODE_SINGLE;
					end
					default: mode_n = MODE_SINGLE;
				endcase
			end

			if (asc) begin
				mode_n = MODE_SINGLE;
				if ((cfg.good_limit != 32'd0) && (good_q >= cfg.good_limit)) begin
					run.segs[n] = mk_str(STR_OVER);
					n = n + 1'b1;
					stop_n = ST_OVER;
				end else begin
					if (good_q != '1)
						good_n = good_q + 32'd1;
					if (in_byte == CH_NL) begin
						run.segs[n] = mk_raw(in_byte);
						n = n + 1'b1;
						line_n = '0;
					end else begin
						if ((cfg.line_limit != 16'd0) && (line_q >= cfg.line_limit)) begin
							run.segs[n] = mk_str(STR_SPLIT);
							n = n + 1'b1;
							line_n = 16'd1;
						end else if (line_q != '1) begin
							line_n = line_q + 16'd1;
						end
						if (in_byte == CH_TAB) begin
							run.segs[n] = mk_raw(in_byte);
							n = n + 1'b1;
						end else if ((in_byte < CH_SP) || (in_byte == CH_DEL)) begin
							bad_inc = 1'b1;
							run.segs[n] = mk_str(STR_BAD);
							n = n + 1'b1;
							run.segs[n] = mk_hex(in_byte);
							n = n + 1'b1;
						end else if (cfg.escape_enable && (in_byte == CH_AMP)) begin
							run.segs[n] = mk_str(STR_AMP);
							n = n + 1'b1;
						end else if (cfg.escape_enable && (in_byte == CH_LT)) begin
							run.segs[n] = mk_str(STR_LT);
							n = n + 1'b1;
						end else if (cfg.escape_enable && (in_byte == CH_GT)) begin
							run.segs[n] = mk_str(STR_GT);
							n = n + 1'b1;
						end else if (cfg.escape_enable && (in_byte == CH_APOS)) begin
							run.segs[n] = mk_str(STR_APOS);
							n = n + 1'b1;
						end else if (cfg.escape_enable && (in_byte == CH_QUOT)) begin
							run.segs[n] = mk_str(STR_QUOT);
							n = n + 1'b1;
						end else begin
							run.segs[n] = mk_raw(in_byte);
							n = n + 1'b1;
						end
					end
				end
			end

			if (bad_inc && (bad_q != '1))
				bad_n = bad_q + 32'd1;
		end

		run.count  = n;
		run.status = stop_n;
	end

	assign push      = accept && (n != '0);
	assign push_data = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SINGLE;
			bad_q  <= '0;
			good_q <= '0;
			line_q <= '0;
			stop_q <= ST_RUN;
		end else if (accept) begin
			mode_q <= mode_n;
			bad_q  <= bad_n;
			good_q <= good_n;
			line_q <= line_n;
			stop_q <= stop_n;
		end
	end

	// Held bytes are read only after being written for the current sequence.
	always_ff @(posedge clk) begin
		if (accept)
			held_q <= held_n;
	end

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q != ST_RUN) |=> (stop_q == $past(stop_q)))
		else $error("stop status changed after stopping");

	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(stop_q != ST_RUN) |-> !push)
		else $error("run queued while stopped");

endmodule

### rtl/core/usx_queue.sv
// Small register queue of output runs between front and back end.
module usx_queue #(
	parameter int DEPTH = usx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  usx_pkg::run_t wdata,
	output logic          full,
	input  logic          pop,
	output usx_pkg::run_t rdata,
	output logic          empty
);
	import usx_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	run_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> !empty))
		else $error("queue overrun or underrun");

endmodule

### rtl/core/usx_emit.sv
// Back end: expand queued runs into output bytes, one per cycle while out_ready holds.
module usx_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  usx_pkg::run_t       head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          out_byte,
	output logic                last,
	output logic [1:0]          status
);
	import usx_pkg::*;

	logic [SEG_IDX_W-1:0] seg_idx_q;
	logic [4:0]           off_q;
	logic                 out_valid_q, last_q;
	logic [7:0]           byte_q;
	status_t              status_q;

	seg_t       seg;
	logic [4:0] seg_len;
	logic [7:0] ch;
	logic       seg_end, run_end, advance;

	assign seg = head.segs[seg_idx_q];

	always_comb begin
		case (seg.kind)
			SEG_STR: seg_len = str_len(seg.id);
			SEG_HEX: seg_len = 5'd4;
			default: seg_len = 5'd1;
		endcase
	end

	always_comb begin
		case (seg.kind)
			SEG_STR: ch = str_char(seg.id, off_q);
			SEG_HEX: begin
				case (off_q[1:0])
					2'd0:    ch = 8'h7B;
					2'd1:    ch = hex_char(seg.data[7:4]);
					2'd2:    ch = hex_char(seg.data[3:0]);
					default: ch = 8'h7D;
				endcase
			end
			default: ch = seg.data;
		endcase
	end

	assign seg_end = (off_q == seg_len - 5'd1);
	assign run_end = seg_end && (seg_idx_q == SEG_IDX_W'(head.count - 1'b1));
	assign advance = !empty && (!out_valid_q || out_ready);
	assign pop     = advance && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q   <= '0;
			off_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			if (run_end) begin
				seg_idx_q <= '0;
				off_q     <= '0;
			end else if (seg_end) begin
				seg_idx_q <= seg_idx_q + 1'b1;
				off_q     <= '0;
			end else begin
				off_q <= off_q + 5'd1;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= ch;
			last_q   <= run_end;
			status_q <= head.status;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;
	assign status    = status_q;

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((head.count != '0) &&
		            (SEG_CNT_W'(seg_idx_q) < head.count)))
		else $error("segment index outside queued run");

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> ((seg_idx_q == '0) && (off_q == '0) && last))
		else $error("run end did not rewind or mark last");

endmodule
